### rtl/cpd_pkg.sv
// Shared types and constants of the cascaded PD steering core.
package cpd_pkg;

  // Field widths
  localparam int unsigned OFS_W      = 16;
  localparam int unsigned HDG_W      = 16;
  localparam int unsigned DT_W       = 20;
  localparam int unsigned GAIN_W     = 24;
  localparam int unsigned LIM_W      = 16;
  localparam int unsigned PWM_W      = 10;
  localparam int unsigned ERR_W      = 17;

  // Magnitude of the widest numerator, and one sign bit on top of it
  localparam int unsigned MAG_W      = 62;
  localparam int unsigned SUM_W      = MAG_W + 1;

  // Serial multiplier takes one multiplier bit per cycle
  localparam int unsigned MUL_B_W    = DT_W;
  localparam int unsigned MUL_CNT_W  = $clog2(MUL_B_W + 1);
  localparam int unsigned DIV_CNT_W  = $clog2(MAG_W + 1);

  // Inner loop result is scaled down by two to the power of this
  localparam int unsigned STEER_SHIFT = 24;

  localparam logic [DT_W-1:0] US_PER_S = DT_W'(1000000);

  localparam int PWM_MIN = 0;
  localparam int PWM_MAX = 1023;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_KP       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_KD       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEADING_KP      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEADING_KD      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HEADING_FLOOR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HEADING_CEILING = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_THROTTLE   = 3'd6;

  // Stream payload widths
  localparam int unsigned S_TDATA_W = 56;
  localparam int unsigned M_TDATA_W = 24;

  typedef struct packed {
    logic               start;
    logic [MAG_W-1:0]   a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] dividend;
    logic [DT_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] quot;
  } div_rsp_t;

endpackage

### rtl/cpd_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
module cpd_mul import cpd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  logic [MUL_CNT_W-1:0] cnt_q;
  logic                 done_q;
  logic [MAG_W-1:0]     acc_q;
  logic [MAG_W-1:0]     mcand_q;
  logic [MUL_B_W-1:0]   mplier_q;

  // Count the steps and flag the last one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (req_i.start) begin
      cnt_q  <= MUL_CNT_W'(MUL_B_W);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - 1'b1;
      done_q <= (cnt_q == MUL_CNT_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  // Add the shifted multiplicand for each set multiplier bit
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q    <= '0;
      mcand_q  <= req_i.a;
      mplier_q <= req_i.b;
    end else if (cnt_q != '0) begin
      if (mplier_q[0]) begin
        acc_q <= acc_q + mcand_q;
      end
      mcand_q  <= {mcand_q[MAG_W-2:0], 1'b0};
      mplier_q <= {1'b0, mplier_q[MUL_B_W-1:1]};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;

endmodule

### rtl/cpd_div.sv
// Restoring divider, one quotient bit per cycle, narrow remainder path.
module cpd_div import cpd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 done_q;
  logic [MAG_W-1:0]     work_q;
  logic [DT_W-1:0]      rem_q;
  logic [DT_W-1:0]      dsr_q;
  logic [DT_W:0]        rem_sh;
  logic [DT_W:0]        rem_sub;
  logic                 fits;

  // Trial subtract of the divisor from the shifted remainder
  always_comb begin
    rem_sh  = {rem_q, work_q[MAG_W-1]};
    rem_sub = rem_sh - {1'b0, dsr_q};
    fits    = (rem_sh >= {1'b0, dsr_q});
  end

  // Count the steps and flag the last one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (req_i.start) begin
      cnt_q  <= DIV_CNT_W'(MAG_W);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - 1'b1;
      done_q <= (cnt_q == DIV_CNT_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  // Shift the dividend out and the quotient bits in
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      work_q <= req_i.dividend;
      rem_q  <= '0;
      dsr_q  <= req_i.divisor;
    end else if (cnt_q != '0) begin
      work_q <= {work_q[MAG_W-2:0], fits};
      rem_q  <= fits ? rem_sub[DT_W-1:0] : rem_sh[DT_W-1:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = work_q;

endmodule

### rtl/cascaded_pd_steering_core.sv
// Each loop runs four serial multiplies with the D term or two without, a sum step
// and a divide; the shared bit-serial multiplier and the 62-step restoring divider
// are used in turn, so a new request is taken only once the last one is through.
// Reset clears gains to zero, limits to full range, and the D-term history and flags.
// The output register lets a new request start while a result waits to be taken.
module cascaded_pd_steering_core import cpd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Sample channel
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [15:0] lane_offset, [31:16] heading, [51:32] elapsed_us, [55:52] zero
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,
  // [0] op
  input  logic                  s_axis_tuser,
  // Result channel
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [9:0] left_pwm, [19:10] right_pwm, [23:20] zero
  output logic [M_TDATA_W-1:0]  m_axis_tdata,
  // Configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_GO,
    S_MUL_WAIT,
    S_SUM,
    S_DIV_GO,
    S_DIV_WAIT,
    S_OUT
  } state_e;

  typedef enum logic [1:0] {
    STEP_P_GAIN,
    STEP_P_DT,
    STEP_D_GAIN,
    STEP_D_SCALE
  } step_e;

  localparam int unsigned SETP_W  = ERR_W + 2;
  localparam int unsigned STEER_W = PWM_W + 3;
  localparam int unsigned QSTR_W  = STEER_W - 2;

  // Configuration registers
  logic [GAIN_W-1:0] offset_kp_q, offset_kd_q, heading_kp_q, heading_kd_q;
  logic [LIM_W-1:0]  heading_floor_q, heading_ceiling_q;
  logic [PWM_W-1:0]  base_throttle_q;

  // Sequencer state
  state_e            state_q;
  step_e             step_q;
  logic              inner_q;
  logic              started_q, halted_q, use_d_q;
  logic              m_valid_q;
  logic [ERR_W-1:0]  err_q, last_oe_q, last_he_q;
  logic [HDG_W-1:0]  heading_q;
  logic [DT_W-1:0]   dt_q;
  logic [MAG_W-1:0]  prod_q, t1_q, t2_q;
  logic [SUM_W-1:0]  sum_q;
  logic [PWM_W-1:0]  res_left_q, res_right_q;
  logic [M_TDATA_W-1:0] m_data_q;

  // Unit interfaces
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // Operand selection
  logic [GAIN_W-1:0] kp_sel, kd_sel, kp_mag, kd_mag;
  logic [ERR_W-1:0]  err_mag, last_sel;
  logic [ERR_W:0]    derr, derr_mag;
  logic              s1, s2;
  logic [SUM_W-1:0]  t1_s, t2_s, sum_d;

  // Result shaping
  logic [ERR_W-1:0]          q_sat;
  logic signed [SETP_W-1:0]  setp_raw, floor_x, ceil_x, setp_clamp;
  logic [ERR_W-1:0]          h_next;
  logic [QSTR_W-1:0]         qs_str;
  logic signed [STEER_W-1:0] steer, left_raw, right_raw, pwm_lo, pwm_hi;
  logic signed [STEER_W-1:0] left_cl, right_cl;

  logic in_acc;
  logic [DT_W-1:0] in_dt;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_dt         = s_axis_tdata[51:32];
  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // Take register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_kp_q       <= '0;
      offset_kd_q       <= '0;
      heading_kp_q      <= '0;
      heading_kd_q      <= '0;
      heading_floor_q   <= 16'h8000;
      heading_ceiling_q <= 16'h7fff;
      base_throttle_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_OFFSET_KP:       offset_kp_q       <= cfg_data_i;
        REG_OFFSET_KD:       offset_kd_q       <= cfg_data_i;
        REG_HEADING_KP:      heading_kp_q      <= cfg_data_i;
        REG_HEADING_KD:      heading_kd_q      <= cfg_data_i;
        REG_HEADING_FLOOR:   heading_floor_q   <= cfg_data_i[LIM_W-1:0];
        REG_HEADING_CEILING: heading_ceiling_q <= cfg_data_i[LIM_W-1:0];
        REG_BASE_THROTTLE:   base_throttle_q   <= cfg_data_i[PWM_W-1:0];
        default: ;
      endcase
    end
  end

  // Pick gains, error magnitudes and signs for the current loop
  always_comb begin
    kp_sel   = inner_q ? heading_kp_q : offset_kp_q;
    kd_sel   = inner_q ? heading_kd_q : offset_kd_q;
    kp_mag   = kp_sel[GAIN_W-1] ? GAIN_W'(-kp_sel) : kp_sel;
    kd_mag   = kd_sel[GAIN_W-1] ? GAIN_W'(-kd_sel) : kd_sel;
    err_mag  = err_q[ERR_W-1] ? ERR_W'(-err_q) : err_q;
    last_sel = inner_q ? last_he_q : last_oe_q;
    derr     = {err_q[ERR_W-1], err_q} - {last_sel[ERR_W-1], last_sel};
    derr_mag = derr[ERR_W] ? (ERR_W+1)'(-derr) : derr;
    s1       = kp_sel[GAIN_W-1] ^ err_q[ERR_W-1];
    s2       = kd_sel[GAIN_W-1] ^ derr[ERR_W];

    mul_req.start = (state_q == S_MUL_GO);
    case (step_q)
      STEP_P_GAIN: begin
        mul_req.a = MAG_W'(kp_mag);
        mul_req.b = MUL_B_W'(err_mag);
      end
      STEP_P_DT: begin
        mul_req.a = prod_q;
        mul_req.b = dt_q;
      end
      STEP_D_GAIN: begin
        mul_req.a = MAG_W'(kd_mag);
        mul_req.b = MUL_B_W'(derr_mag);
      end
      STEP_D_SCALE: begin
        mul_req.a = prod_q;
        mul_req.b = US_PER_S;
      end
      default: begin
        mul_req.a = '0;
        mul_req.b = '0;
      end
    endcase

    t1_s  = s1 ? SUM_W'(-{1'b0, t1_q}) : {1'b0, t1_q};
    t2_s  = s2 ? SUM_W'(-{1'b0, t2_q}) : {1'b0, t2_q};
    sum_d = t1_s + t2_s;

    div_req.start    = (state_q == S_DIV_GO);
    div_req.dividend = sum_q[SUM_W-1] ? MAG_W'(-sum_q) : sum_q[MAG_W-1:0];
    div_req.divisor  = dt_q;
  end

  // Saturate the quotient, then clamp the setpoint or the wheel levels
  always_comb begin
    q_sat      = (|div_rsp.quot[MAG_W-1:ERR_W]) ? '1 : div_rsp.quot[ERR_W-1:0];
    setp_raw   = sum_q[SUM_W-1] ? -$signed({2'b00, q_sat}) : $signed({2'b00, q_sat});
    floor_x    = $signed({{(SETP_W-LIM_W){heading_floor_q[LIM_W-1]}}, heading_floor_q});
    ceil_x     = $signed({{(SETP_W-LIM_W){heading_ceiling_q[LIM_W-1]}}, heading_ceiling_q});
    if (setp_raw < floor_x) begin
      setp_clamp = floor_x;
    end else if (setp_raw > ceil_x) begin
      setp_clamp = ceil_x;
    end else begin
      setp_clamp = setp_raw;
    end
    h_next = {heading_q[HDG_W-1], heading_q}
           - {setp_clamp[LIM_W-1], setp_clamp[LIM_W-1:0]};

    qs_str = (|div_rsp.quot[MAG_W-1:STEER_SHIFT+QSTR_W]) ? '1
           : div_rsp.quot[STEER_SHIFT+QSTR_W-1:STEER_SHIFT];
    steer  = sum_q[SUM_W-1] ? -$signed({2'b00, qs_str}) : $signed({2'b00, qs_str});
    left_raw  = $signed({3'b000, base_throttle_q}) + steer;
    right_raw = $signed({3'b000, base_throttle_q}) - steer;
    pwm_lo    = $signed(STEER_W'(PWM_MIN));
    pwm_hi    = $signed(STEER_W'(PWM_MAX));
    if (left_raw < pwm_lo) begin
      left_cl = pwm_lo;
    end else if (left_raw > pwm_hi) begin
      left_cl = pwm_hi;
    end else begin
      left_cl = left_raw;
    end
    if (right_raw < pwm_lo) begin
      right_cl = pwm_lo;
    end else if (right_raw > pwm_hi) begin
      right_cl = pwm_hi;
    end else begin
      right_cl = right_raw;
    end
  end

  // Sequence both loops through the shared multiplier and divider
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= STEP_P_GAIN;
      inner_q     <= 1'b0;
      started_q   <= 1'b0;
      halted_q    <= 1'b0;
      use_d_q     <= 1'b0;
      m_valid_q   <= 1'b0;
      last_oe_q   <= '0;
      last_he_q   <= '0;
      err_q       <= '0;
      heading_q   <= '0;
      dt_q        <= '0;
      prod_q      <= '0;
      t1_q        <= '0;
      t2_q        <= '0;
      sum_q       <= '0;
      res_left_q  <= '0;
      res_right_q <= '0;
      m_data_q    <= '0;
    end else begin
      // Drop a taken result; the output state reloads the register itself
      if (m_valid_q && m_axis_tready && (state_q != S_OUT)) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc && s_axis_tuser) begin
            halted_q <= 1'b1;
          end else if (in_acc) begin
            if (!started_q) begin
              started_q <= 1'b1;
              use_d_q   <= 1'b0;
              dt_q      <= DT_W'(1);
            end else if (halted_q) begin
              halted_q  <= 1'b0;
              use_d_q   <= 1'b0;
              dt_q      <= DT_W'(1);
            end else begin
              use_d_q   <= 1'b1;
              dt_q      <= (in_dt == '0) ? DT_W'(1) : in_dt;
            end
            err_q     <= {s_axis_tdata[OFS_W-1], s_axis_tdata[OFS_W-1:0]};
            heading_q <= s_axis_tdata[31:16];
            inner_q   <= 1'b0;
            step_q    <= STEP_P_GAIN;
            t2_q      <= '0;
            state_q   <= S_MUL_GO;
          end
        end
        S_MUL_GO: begin
          state_q <= S_MUL_WAIT;
        end
        S_MUL_WAIT: begin
          if (mul_rsp.done) begin
            case (step_q)
              STEP_P_GAIN: begin
                prod_q  <= mul_rsp.prod;
                step_q  <= STEP_P_DT;
                state_q <= S_MUL_GO;
              end
              STEP_P_DT: begin
                t1_q    <= mul_rsp.prod;
                step_q  <= STEP_D_GAIN;
                state_q <= use_d_q ? S_MUL_GO : S_SUM;
              end
              STEP_D_GAIN: begin
                prod_q  <= mul_rsp.prod;
                step_q  <= STEP_D_SCALE;
                state_q <= S_MUL_GO;
              end
              STEP_D_SCALE: begin
                t2_q    <= mul_rsp.prod;
                state_q <= S_SUM;
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_SUM: begin
          sum_q   <= sum_d;
          state_q <= S_DIV_GO;
        end
        S_DIV_GO: begin
          state_q <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_rsp.done) begin
            if (!inner_q) begin
              // Outer loop done: keep its error, start the inner loop on h
              last_oe_q <= err_q;
              err_q     <= h_next;
              inner_q   <= 1'b1;
              step_q    <= STEP_P_GAIN;
              t2_q      <= '0;
              state_q   <= S_MUL_GO;
            end else begin
              last_he_q   <= err_q;
              res_left_q  <= left_cl[PWM_W-1:0];
              res_right_q <= right_cl[PWM_W-1:0];
              state_q     <= S_OUT;
            end
          end
        end
        S_OUT: begin
          // Hold until the output register is free
          if (!m_valid_q || m_axis_tready) begin
            m_data_q  <= {(M_TDATA_W-2*PWM_W)'(0), res_right_q, res_left_q};
            m_valid_q <= 1'b1;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  cpd_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  cpd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // No request is taken while a sample is being worked on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !s_axis_tready)
    else $error("request accepted while busy");

  // A halt request always leaves the halted flag set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser) |=> halted_q)
    else $error("halt request lost");

  // Divider results arrive only while the sequencer waits for them
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DIV_WAIT))
    else $error("divider result outside its wait state");

  // Without the D term the second product stays zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SUM && !use_d_q) |-> (t2_q == '0))
    else $error("D term used on a restart sample");

  // A result ready with a free output register is shown in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && !m_valid_q) |=> (m_valid_q && state_q == S_IDLE))
    else $error("result not loaded into the output register");

endmodule
